/* rtl/core/lslf_pkg.sv */
// Package: types, constants and command/status structs of the line-fit block.
`timescale 1ns / 1ps
`default_nettype none
package lslf_pkg;

	localparam int unsigned MAX_POINTS_DEF = 1024;
	localparam int unsigned X_W            = 16;
	localparam int unsigned OUT_W          = 48;
	localparam int unsigned PCNT_W         = 11;
	localparam int unsigned SLOPE_SHIFT    = 16;
	localparam int unsigned ICPT_SHIFT     = 8;

	typedef struct packed {
		logic signed [X_W-1:0] x_value;
		logic signed [X_W-1:0] y_value;
		logic                  last_point;
	} lslf_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] slope;
		logic signed [OUT_W-1:0] intercept;
		logic [PCNT_W-1:0]       point_count;
		logic                    degenerate;
		logic                    overflowed;
	} lslf_out_t;

	// product terms, in evaluation order; odd members are subtracted
	typedef enum logic [2:0] {
		P_N_XX = 3'd0,
		P_X_X  = 3'd1,
		P_N_XY = 3'd2,
		P_X_Y  = 3'd3,
		P_Y_XX = 3'd4,
		P_X_XY = 3'd5
	} lslf_prod_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MLOAD,
		ST_MRUN,
		ST_PAIR,
		ST_DLOAD,
		ST_DRUN,
		ST_DSAVE,
		ST_DONE
	} lslf_state_t;

	typedef struct packed {
		logic       accum;
		logic       clear_sums;
		lslf_prod_t sel;
		logic       mul_load;
		logic       mul_sub;
		logic       acc_clr;
		logic       mul_step;
		logic       save_delta;
		logic       div_load;
		logic       div_step;
		logic       div_save;
		logic       div_slope;
	} lslf_cmd_t;

	typedef struct packed {
		logic delta_zero;
	} lslf_stat_t;

endpackage
`default_nettype wire

/* rtl/core/lslf_datapath.sv */
// Datapath: running sums, shift-add multiply-accumulate, restoring divider, results.
`timescale 1ns / 1ps
`default_nettype none
module lslf_datapath #(
	parameter int unsigned MAX_POINTS = lslf_pkg::MAX_POINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lslf_pkg::lslf_in_t  point,
	input  wire lslf_pkg::lslf_cmd_t cmd,
	output lslf_pkg::lslf_stat_t     stat,
	output lslf_pkg::lslf_out_t      result
);
	import lslf_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
	localparam int unsigned SX_W  = X_W + CNT_W;
	localparam int unsigned SXY_W = 2 * X_W - 1 + CNT_W;
	localparam int unsigned AW    = 3 * X_W + 2 * CNT_W;
	localparam int unsigned DW    = 2 * X_W - 2 + 2 * CNT_W;
	localparam int unsigned NW    = AW + ICPT_SHIFT;
	localparam logic [NW-1:0] LIM = NW'(1) << (OUT_W - 1);

	logic signed [SX_W-1:0]    sum_x_q, sum_y_q;
	logic signed [SXY_W-1:0]   sum_xy_q, sum_xx_q;
	logic [CNT_W-1:0]          count_q;
	logic                      drop_q;
	logic signed [2*X_W-1:0]   xy_prod, xx_prod;

	logic signed [SXY_W-1:0]   a_op;
	logic signed [SX_W-1:0]    b_op;
	logic [SXY_W-1:0]          a_mag;
	logic [SX_W-1:0]           b_mag;
	logic [AW-1:0]             mul_a_q;
	logic [SX_W-1:0]           mul_b_q;
	logic                      mul_neg_q;
	logic signed [AW-1:0]      acc_q;
	logic [AW-1:0]             acc_mag;

	logic [NW-1:0]             num_q;
	logic [DW-1:0]             rem_q, delta_q;
	logic                      dneg_q;
	logic [DW:0]               trial;
	logic                      ge;
	logic [NW-1:0]             q_neg;
	logic [OUT_W-1:0]          sat_val;

	logic signed [OUT_W-1:0]   slope_q, icpt_q;
	logic                      degen_q;

	assign xy_prod = point.x_value * point.y_value;
	assign xx_prod = point.x_value * point.x_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
			count_q  <= '0;
			drop_q   <= 1'b0;
		end else if (cmd.clear_sums) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xy_q <= '0;
			sum_xx_q <= '0;
			count_q  <= '0;
			drop_q   <= 1'b0;
		end else if (cmd.accum) begin
			if (count_q < CNT_W'(MAX_POINTS)) begin
				sum_x_q  <= sum_x_q + SX_W'(point.x_value);
				sum_y_q  <= sum_y_q + SX_W'(point.y_value);
				sum_xy_q <= sum_xy_q + SXY_W'(xy_prod);
				sum_xx_q <= sum_xx_q + SXY_W'(xx_prod);
				count_q  <= count_q + CNT_W'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// operand pairs; b is always the narrow one
	always_comb begin
		unique case (cmd.sel)
			P_N_XX: begin
				a_op = sum_xx_q;
				b_op = $signed(SX_W'(count_q));
			end
			P_X_X: begin
				a_op = SXY_W'(sum_x_q);
				b_op = sum_x_q;
			end
			P_N_XY: begin
				a_op = sum_xy_q;
				b_op = $signed(SX_W'(count_q));
			end
			P_X_Y: begin
				a_op = SXY_W'(sum_y_q);
				b_op = sum_x_q;
			end
			P_Y_XX: begin
				a_op = sum_xx_q;
				b_op = sum_y_q;
			end
			P_X_XY: begin
				a_op = sum_xy_q;
				b_op = sum_x_q;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign a_mag   = a_op[SXY_W-1] ? SXY_W'(-a_op) : SXY_W'(a_op);
	assign b_mag   = b_op[SX_W-1] ? SX_W'(-b_op) : SX_W'(b_op);
	assign acc_mag = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);

	assign stat.delta_zero = acc_q[AW-1] || (acc_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			mul_a_q   <= AW'(a_mag);
			mul_b_q   <= b_mag;
			mul_neg_q <= a_op[SXY_W-1] ^ b_op[SX_W-1] ^ cmd.mul_sub;
			if (cmd.acc_clr) begin
				acc_q <= '0;
			end
		end else if (cmd.mul_step) begin
			if (mul_b_q[0]) begin
				acc_q <= mul_neg_q ? acc_q - $signed(mul_a_q) : acc_q + $signed(mul_a_q);
			end
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
		end
	end

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, delta_q};

	always_ff @(posedge clk) begin
		if (cmd.save_delta) begin
			delta_q <= acc_q[DW-1:0];
		end
		if (cmd.div_load) begin
			num_q  <= NW'(acc_mag) << (cmd.div_slope ? SLOPE_SHIFT : ICPT_SHIFT);
			rem_q  <= '0;
			dneg_q <= acc_q[AW-1];
		end else if (cmd.div_step) begin
			rem_q <= ge ? DW'(trial - {1'b0, delta_q}) : DW'(trial);
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	// saturate the quotient to signed 48 bits
	assign q_neg = '0 - num_q;
	always_comb begin
		if (dneg_q) begin
			sat_val = (num_q > LIM) ? OUT_W'(LIM) : q_neg[OUT_W-1:0];
		end else begin
			sat_val = (num_q >= LIM) ? OUT_W'(LIM - NW'(1)) : num_q[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.save_delta) begin
			slope_q <= '0;
			icpt_q  <= '0;
			degen_q <= stat.delta_zero;
		end else if (cmd.div_save) begin
			if (cmd.div_slope) begin
				slope_q <= $signed(sat_val);
			end else begin
				icpt_q <= $signed(sat_val);
			end
		end
	end

	assign result.slope       = slope_q;
	assign result.intercept   = icpt_q;
	assign result.point_count = PCNT_W'(count_q);
	assign result.degenerate  = degen_q;
	assign result.overflowed  = drop_q;

endmodule
`default_nettype wire

/* rtl/core/lslf_ctrl.sv */
// Controller: sequences accumulation, the six products, and the two divisions.
`timescale 1ns / 1ps
`default_nettype none
module lslf_ctrl #(
	parameter int unsigned MAX_POINTS = lslf_pkg::MAX_POINTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                last_point,
	input  wire lslf_pkg::lslf_stat_t stat,
	output logic                     busy,
	output logic                     done,
	output lslf_pkg::lslf_cmd_t       cmd
);
	import lslf_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
	localparam int unsigned SX_W  = X_W + CNT_W;
	localparam int unsigned NW    = 3 * X_W + 2 * CNT_W + ICPT_SHIFT;
	localparam int unsigned CTR_W = $clog2(NW);

	lslf_state_t      state_q, state_d;
	lslf_prod_t       prod_q, prod_d, prod_next;
	logic [CTR_W-1:0] cnt_q, cnt_d;
	logic             sub;

	assign sub = (prod_q == P_X_X) || (prod_q == P_X_Y) || (prod_q == P_X_XY);

	always_comb begin
		unique case (prod_q)
			P_N_XX:  prod_next = P_X_X;
			P_N_XY:  prod_next = P_X_Y;
			P_Y_XX:  prod_next = P_X_XY;
			default: prod_next = prod_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prod_q  <= P_N_XX;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			prod_q  <= prod_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.sel       = prod_q;
		cmd.mul_sub   = sub;
		cmd.acc_clr   = !sub;
		cmd.div_slope = (prod_q == P_X_Y);
		state_d       = state_q;
		prod_d        = prod_q;
		cnt_d         = cnt_q;
		busy          = 1'b1;
		done          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.accum = start;
				if (start && last_point) begin
					prod_d  = P_N_XX;
					state_d = ST_MLOAD;
				end
			end
			ST_MLOAD: begin
				cmd.mul_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MRUN;
			end
			ST_MRUN: begin
				cmd.mul_step = 1'b1;
				cnt_d        = CTR_W'(cnt_q + 1'b1);
				if (cnt_q == CTR_W'(SX_W - 1)) begin
					if (sub) begin
						state_d = ST_PAIR;
					end else begin
						prod_d  = prod_next;
						state_d = ST_MLOAD;
					end
				end
			end
			ST_PAIR: begin
				if (prod_q == P_X_X) begin
					cmd.save_delta = 1'b1;
					if (stat.delta_zero) begin
						state_d = ST_DONE;
					end else begin
						prod_d  = P_N_XY;
						state_d = ST_MLOAD;
					end
				end else begin
					state_d = ST_DLOAD;
				end
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DRUN;
			end
			ST_DRUN: begin
				cmd.div_step = 1'b1;
				cnt_d        = CTR_W'(cnt_q + 1'b1);
				if (cnt_q == CTR_W'(NW - 1)) begin
					state_d = ST_DSAVE;
				end
			end
			ST_DSAVE: begin
				cmd.div_save = 1'b1;
				if (prod_q == P_X_Y) begin
					prod_d  = P_Y_XX;
					state_d = ST_MLOAD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done           = 1'b1;
				cmd.clear_sums = 1'b1;
				state_d        = ST_IDLE;
			end
		endcase
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a fit");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
	a_plain_request: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_point) |=> !busy)
		else $error("busy after a request that does not end the set");
	a_last_request: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_point) |=> (busy && !done))
		else $error("fit not started after the final request");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_step && cmd.div_step) && !(cmd.accum && busy))
		else $error("conflicting datapath commands");

endmodule
`default_nettype wire

/* rtl/core/least_squares_line_fit.sv */
// Top level of the least-squares straight-line fit block.
//
//  channel   ports                      direction  handshake
//  request   start, busy, point         in         accepted when start && !busy
//  result    done, result               out        valid for the single cycle done is high
//
// A request without last_point is absorbed while busy stays low.
// A request with last_point starts the fit; busy then stays high while the
//   bit-serial multiplier forms the six products and the one-bit-per-cycle
//   divider forms the slope and then the intercept; a degenerate set ends
//   once the first pair of products gives a delta of zero or below. done
//   marks the last busy cycle.
// Reset clears all sums; the result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module least_squares_line_fit #(
	parameter int unsigned MAX_POINTS = lslf_pkg::MAX_POINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire lslf_pkg::lslf_in_t  point,
	output logic                    done,
	output lslf_pkg::lslf_out_t      result
);
	import lslf_pkg::*;

	lslf_cmd_t  cmd;
	lslf_stat_t stat;

	lslf_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_point(point.last_point),
		.stat      (stat),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	lslf_datapath #(
		.MAX_POINTS(MAX_POINTS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.point (point),
		.cmd   (cmd),
		.stat  (stat),
		.result(result)
	);

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the least-squares line fit: random and directed point sets.
`timescale 1ns / 1ps
module testbench;
	import lslf_pkg::*;

	typedef enum int {
		MIX_FULL,
		MIX_SMALL,
		MIX_LINE,
		MIX_SAME_X,
		MIX_EDGE
	} set_mix_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	lslf_in_t  point = '0;
	logic      busy;
	logic      done;
	lslf_out_t result;

	lslf_in_t  point_queue[$];
	lslf_out_t pending_fits[$];
	lslf_out_t want;
	int        error_count = 0;
	int        gap_left;
	logic      steady;

	// running sums of the fit in progress
	longint    sum_x, sum_y, sum_xy, sum_xx;
	int        kept_count;
	logic      lost_points;

	least_squares_line_fit #(.MAX_POINTS(MAX_POINTS_DEF)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.point  (point),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// fixed-point quotient (Q32.16 slope, Q40.8 intercept), truncated toward zero, clamped to 48 bits
	function automatic logic signed [OUT_W-1:0] fit_quotient(
		input logic signed [127:0] num,
		input logic signed [127:0] den
	);
		logic [127:0] mag;
		logic [127:0] q;
		logic [127:0] lim;
		lim = 128'd1 << (OUT_W - 1);
		mag = num[127] ? -num : num;
		q = mag / $unsigned(den);
		if (num[127]) begin
			if (q > lim)
				return {1'b1, {(OUT_W-1){1'b0}}};
			return -q[OUT_W-1:0];
		end
		if (q > lim - 1)
			return {1'b0, {(OUT_W-1){1'b1}}};
		return q[OUT_W-1:0];
	endfunction

	task automatic absorb_point(input lslf_in_t p);
		lslf_out_t r;
		logic signed [127:0] n_w, sx_w, sy_w, sxy_w, sxx_w, delta;
		if (kept_count < MAX_POINTS_DEF) begin
			sum_x += longint'(p.x_value);
			sum_y += longint'(p.y_value);
			sum_xy += longint'(p.x_value) * longint'(p.y_value);
			sum_xx += longint'(p.x_value) * longint'(p.x_value);
			kept_count++;
		end else
			lost_points = 1'b1;
		if (p.last_point) begin
			n_w = kept_count;
			sx_w = sum_x;
			sy_w = sum_y;
			sxy_w = sum_xy;
			sxx_w = sum_xx;
			delta = n_w * sxx_w - sx_w * sx_w;
			r.point_count = PCNT_W'(kept_count);
			r.overflowed = lost_points;
			if (delta <= 0) begin
				r.slope = '0;
				r.intercept = '0;
				r.degenerate = 1'b1;
			end else begin
				r.slope = fit_quotient((n_w * sxy_w - sx_w * sy_w) <<< SLOPE_SHIFT, delta);
				r.intercept = fit_quotient((sxx_w * sy_w - sx_w * sxy_w) <<< ICPT_SHIFT,
					delta);
				r.degenerate = 1'b0;
			end
			pending_fits.push_back(r);
			sum_x = 0;
			sum_y = 0;
			sum_xy = 0;
			sum_xx = 0;
			kept_count = 0;
			lost_points = 1'b0;
		end
	endtask

	task automatic queue_point(input int xv, input int yv, input bit last);
		lslf_in_t p;
		p.x_value = xv[X_W-1:0];
		p.y_value = yv[X_W-1:0];
		p.last_point = last;
		point_queue.push_back(p);
	endtask

	function automatic int rand16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int edge_pick();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic add_random_sets(input int budget);
		int used, set_len, k, xv, yv, gain, offs, base_x;
		set_mix_t mix;
		used = 0;
		while (used < budget) begin
			set_len = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(2, 24));
			mix = set_mix_t'($urandom_range(0, 4));
			gain = int'($urandom_range(0, 8)) - 4;
			offs = int'($urandom_range(0, 2000)) - 1000;
			base_x = rand16();
			for (k = 0; k < set_len; k++) begin
				case (mix)
					MIX_FULL: begin
						xv = rand16();
						yv = rand16();
					end
					MIX_SMALL: begin
						xv = int'($urandom_range(0, 255)) - 128;
						yv = int'($urandom_range(0, 255)) - 128;
					end
					MIX_LINE: begin
						xv = int'($urandom_range(0, 4000)) - 2000;
						yv = gain * xv + offs + int'($urandom_range(0, 6)) - 3;
					end
					MIX_SAME_X: begin
						xv = base_x;
						yv = rand16();
					end
					default: begin
						xv = edge_pick();
						yv = edge_pick();
					end
				endcase
				queue_point(xv, yv, k == set_len - 1);
			end
			used += set_len;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			point <= '0;
			gap_left <= 0;
			steady <= 1'b0;
		end else begin
			if (start && !busy)
				absorb_point(point);
			if (!start || !busy) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (point_queue.size() != 0) begin
					point <= point_queue.pop_front();
					start <= 1'b1;
					if ($urandom_range(0, 99) < 3)
						steady <= ~steady;
					gap_left <= steady ? 0 : int'($urandom_range(0, 10));
				end else
					start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_fits.size() == 0)
				flag_error("result with no fit pending");
			else begin
				want = pending_fits.pop_front();
				if (result.slope !== want.slope)
					flag_error($sformatf("slope: expected %0d, got %0d",
						want.slope, result.slope));
				if (result.intercept !== want.intercept)
					flag_error($sformatf("intercept: expected %0d, got %0d",
						want.intercept, result.intercept));
				if (result.point_count !== want.point_count)
					flag_error($sformatf("point_count: expected %0d, got %0d",
						want.point_count, result.point_count));
				if (result.degenerate !== want.degenerate)
					flag_error($sformatf("degenerate: expected %0b, got %0b",
						want.degenerate, result.degenerate));
				if (result.overflowed !== want.overflowed)
					flag_error($sformatf("overflowed: expected %0b, got %0b",
						want.overflowed, result.overflowed));
			end
		end
	end

	initial begin
		int k, extra;
		sum_x = 0;
		sum_y = 0;
		sum_xy = 0;
		sum_xx = 0;
		kept_count = 0;
		lost_points = 1'b0;

		// single point
		queue_point(0, 0, 1'b1);
		// opposite corners
		queue_point(-32768, -32768, 1'b0);
		queue_point(32767, 32767, 1'b1);
		queue_point(32767, -32768, 1'b0);
		queue_point(-32768, 32767, 1'b1);
		// all x equal
		queue_point(100, 5, 1'b0);
		queue_point(100, -7, 1'b0);
		queue_point(100, 9, 1'b1);
		// exact line, slope 1.0
		queue_point(256, 512, 1'b0);
		queue_point(512, 768, 1'b0);
		queue_point(768, 1024, 1'b0);
		queue_point(1024, 1280, 1'b1);
		// steepest two-point slope
		queue_point(0, -32768, 1'b0);
		queue_point(1, 32767, 1'b1);
		// far from origin, large intercept
		queue_point(32767, -32768, 1'b0);
		queue_point(32766, 32767, 1'b1);
		queue_point(-32768, 32767, 1'b1);

		add_random_sets(350);
		// beyond capacity; the closing point is dropped but still fits
		extra = int'($urandom_range(1, 4));
		for (k = 0; k < MAX_POINTS_DEF + extra; k++)
			queue_point(rand16(), rand16(), k == MAX_POINTS_DEF + extra - 1);
		add_random_sets(350);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (point_queue.size() != 0 || start || busy || pending_fits.size() != 0);
		repeat (400) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
